[rtl/hrc_pkg.sv]
// ----------------------------------------------------------------------------
// hrc_pkg - shared types and constants of the hysteresis relay controller
// Item, result, configuration and state records, register indexes, device
// codes, hysteresis bands and timing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package hrc_pkg;

  // Item action codes
  typedef enum logic [1:0] {
    ACT_CHECK    = 2'd0,
    ACT_OVERRIDE = 2'd1,
    ACT_DISMISS  = 2'd2
  } action_e;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_ENABLE_MASK = 3'd0;
  localparam logic [2:0] REG_TEMP_HIGH   = 3'd1;
  localparam logic [2:0] REG_TEMP_LOW    = 3'd2;
  localparam logic [2:0] REG_HUMI_HIGH   = 3'd3;
  localparam logic [2:0] REG_HUMI_LOW    = 3'd4;
  localparam logic [2:0] REG_SOIL_DRY    = 3'd5;
  localparam logic [2:0] REG_LIGHT_DARK  = 3'd6;
  localparam logic [2:0] REG_CO2_HIGH    = 3'd7;

  // Enable mask bits
  localparam int unsigned EN_TEMP  = 0;
  localparam int unsigned EN_SOIL  = 1;
  localparam int unsigned EN_LIGHT = 2;
  localparam int unsigned EN_CO2   = 3;
  localparam int unsigned EN_HUMI  = 4;

  // Alert bits
  localparam int unsigned ALR_TEMP_HI = 0;
  localparam int unsigned ALR_TEMP_LO = 1;
  localparam int unsigned ALR_HUMI_HI = 2;
  localparam int unsigned ALR_HUMI_LO = 3;
  localparam int unsigned ALR_SOIL    = 4;
  localparam int unsigned ALR_LIGHT   = 5;
  localparam int unsigned ALR_CO2     = 6;

  // Override device codes and their slots
  localparam logic [2:0] DEV_PUMP   = 3'd1;
  localparam logic [2:0] DEV_HEATER = 3'd4;
  localparam logic [1:0] SLOT_PUMP   = 2'd0;
  localparam logic [1:0] SLOT_LAMP   = 2'd1;
  localparam logic [1:0] SLOT_FAN    = 2'd2;
  localparam logic [1:0] SLOT_HEATER = 2'd3;

  // Hysteresis bands, 18-bit signed so limit -/+ band never wraps
  localparam logic signed [17:0] BAND_TEMP  = 18'sd20;
  localparam logic signed [17:0] BAND_HUMI  = 18'sd50;
  localparam logic signed [17:0] BAND_SOIL  = 18'sd200;
  localparam logic signed [17:0] BAND_LIGHT = 18'sd200;
  localparam logic signed [17:0] BAND_CO2   = 18'sd50;

  // Timing
  localparam logic [31:0] OVR_TIMEOUT_MS = 32'd300000;
  localparam logic [31:0] BUZZ_MS        = 32'd5000;

  typedef struct packed {
    logic [4:0]         enable_mask;
    logic signed [15:0] temp_high_limit;
    logic signed [15:0] temp_low_limit;
    logic [15:0]        humi_high_limit;
    logic [15:0]        humi_low_limit;
    logic [15:0]        soil_dry_limit;
    logic [15:0]        light_dark_limit;
    logic [15:0]        co2_high_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    enable_mask:      5'd0,
    temp_high_limit:  16'sd350,
    temp_low_limit:   16'sd100,
    humi_high_limit:  16'd800,
    humi_low_limit:   16'd300,
    soil_dry_limit:   16'd3000,
    light_dark_limit: 16'd3000,
    co2_high_limit:   16'd1500
  };

  typedef struct packed {
    action_e            action;
    logic [31:0]        now_ms;
    logic signed [15:0] temp_tenths;
    logic [15:0]        humi_tenths;
    logic [15:0]        light_level;
    logic [15:0]        soil_level;
    logic [15:0]        co2_level;
    logic [2:0]         device;
  } item_t;

  typedef struct packed {
    logic             fan_temp;
    logic             fan_humi;
    logic             fan_co2;
    logic             heater;
    logic             pump;
    logic             lamp;
    logic             humi_alarm;
    logic [3:0][31:0] ovr_start;
    logic [31:0]      buzz_deadline;
    logic             buzz_on;
  } state_t;

  typedef struct packed {
    logic       fan_write;
    logic       fan_level;
    logic       heater_write;
    logic       heater_level;
    logic       pump_write;
    logic       pump_level;
    logic       lamp_write;
    logic       lamp_level;
    logic       buzzer_active;
    logic [6:0] new_alerts;
    logic       humi_low_flag;
  } res_t;

endpackage

`default_nettype wire

[rtl/hrc_eval.sv]
// ----------------------------------------------------------------------------
// hrc_eval - per-item evaluation of the relay controller
// From the current state, configuration and one item, forms the next state
// and the result word. Purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module hrc_eval (
  input  hrc_pkg::cfg_t   cfg_i,
  input  hrc_pkg::item_t  item_i,
  input  hrc_pkg::state_t state_i,
  output hrc_pkg::state_t state_o,
  output hrc_pkg::res_t   res_o
);
  import hrc_pkg::*;

  // {raise, next flag} for a flag that sets above hi, clears below hi - band
  function automatic logic [1:0] hyst_above(logic f, logic signed [17:0] v,
                                            logic signed [17:0] hi,
                                            logic signed [17:0] band);
    logic raise;
    logic keep;
    raise = !f && (v > hi);
    keep  = f && !(v < (hi - band));
    return {raise, raise | keep};
  endfunction

  // {raise, next flag} for a flag that sets below lo, clears above lo + band
  function automatic logic [1:0] hyst_below(logic f, logic signed [17:0] v,
                                            logic signed [17:0] lo,
                                            logic signed [17:0] band);
    logic raise;
    logic keep;
    raise = !f && (v < lo);
    keep  = f && !(v > (lo + band));
    return {raise, raise | keep};
  endfunction

  // Widened operands
  logic signed [17:0] t_w, h_w, l_w, s_w, c_w;
  logic signed [17:0] thi_w, tlo_w, hhi_w, hlo_w, sdl_w, ldl_w, chi_w;

  assign t_w   = {{2{item_i.temp_tenths[15]}}, item_i.temp_tenths};
  assign h_w   = {2'b00, item_i.humi_tenths};
  assign l_w   = {2'b00, item_i.light_level};
  assign s_w   = {2'b00, item_i.soil_level};
  assign c_w   = {2'b00, item_i.co2_level};
  assign thi_w = {{2{cfg_i.temp_high_limit[15]}}, cfg_i.temp_high_limit};
  assign tlo_w = {{2{cfg_i.temp_low_limit[15]}}, cfg_i.temp_low_limit};
  assign hhi_w = {2'b00, cfg_i.humi_high_limit};
  assign hlo_w = {2'b00, cfg_i.humi_low_limit};
  assign sdl_w = {2'b00, cfg_i.soil_dry_limit};
  assign ldl_w = {2'b00, cfg_i.light_dark_limit};
  assign chi_w = {2'b00, cfg_i.co2_high_limit};

  // Enables
  logic en_temp, en_humi, en_soil, en_light, en_co2, en_fan;
  assign en_temp  = cfg_i.enable_mask[EN_TEMP];
  assign en_humi  = cfg_i.enable_mask[EN_HUMI];
  assign en_soil  = cfg_i.enable_mask[EN_SOIL];
  assign en_light = cfg_i.enable_mask[EN_LIGHT];
  assign en_co2   = cfg_i.enable_mask[EN_CO2];
  assign en_fan   = en_temp | en_humi | en_co2;

  // Hysteresis results
  logic [1:0] h_ft, h_ht, h_fh, h_ha, h_pu, h_la, h_fc;
  assign h_ft = hyst_above(state_i.fan_temp,   t_w, thi_w, BAND_TEMP);
  assign h_ht = hyst_below(state_i.heater,     t_w, tlo_w, BAND_TEMP);
  assign h_fh = hyst_above(state_i.fan_humi,   h_w, hhi_w, BAND_HUMI);
  assign h_ha = hyst_below(state_i.humi_alarm, h_w, hlo_w, BAND_HUMI);
  assign h_pu = hyst_above(state_i.pump,       s_w, sdl_w, BAND_SOIL);
  assign h_la = hyst_above(state_i.lamp,       l_w, ldl_w, BAND_LIGHT);
  assign h_fc = hyst_above(state_i.fan_co2,    c_w, chi_w, BAND_CO2);

  // Flags after a check
  logic f_ft, f_ht, f_fh, f_ha, f_pu, f_la, f_fc, fan_any;
  assign f_ft    = en_temp  ? h_ft[0] : state_i.fan_temp;
  assign f_ht    = en_temp  ? h_ht[0] : state_i.heater;
  assign f_fh    = en_humi  ? h_fh[0] : state_i.fan_humi;
  assign f_ha    = en_humi  ? h_ha[0] : state_i.humi_alarm;
  assign f_pu    = en_soil  ? h_pu[0] : state_i.pump;
  assign f_la    = en_light ? h_la[0] : state_i.lamp;
  assign f_fc    = en_co2   ? h_fc[0] : state_i.fan_co2;
  assign fan_any = f_ft | f_fh | f_fc;

  logic [6:0] alerts;
  always_comb begin
    alerts              = '0;
    alerts[ALR_TEMP_HI] = en_temp  & h_ft[1];
    alerts[ALR_TEMP_LO] = en_temp  & h_ht[1];
    alerts[ALR_HUMI_HI] = en_humi  & h_fh[1];
    alerts[ALR_HUMI_LO] = en_humi  & h_ha[1];
    alerts[ALR_SOIL]    = en_soil  & h_pu[1];
    alerts[ALR_LIGHT]   = en_light & h_la[1];
    alerts[ALR_CO2]     = en_co2   & h_fc[1];
  end

  // Override slots: live check per slot, expiry clears only when looked at
  logic [3:0] checked, live, expired;
  always_comb begin
    checked              = '0;
    checked[SLOT_PUMP]   = en_soil;
    checked[SLOT_LAMP]   = en_light;
    checked[SLOT_FAN]    = en_fan;
    checked[SLOT_HEATER] = en_temp;
    for (int i = 0; i < 4; i++) begin
      live[i]    = (state_i.ovr_start[i] != '0) &&
                   ((item_i.now_ms - state_i.ovr_start[i]) < OVR_TIMEOUT_MS);
      expired[i] = checked[i] && (state_i.ovr_start[i] != '0) && !live[i];
    end
  end

  logic        dev_ok;
  logic [1:0]  dev_slot;
  logic [31:0] ovr_stamp;
  assign dev_ok    = (item_i.device >= DEV_PUMP) && (item_i.device <= DEV_HEATER);
  assign dev_slot  = 2'(item_i.device - DEV_PUMP);
  assign ovr_stamp = (item_i.now_ms == '0) ? 32'd1 : item_i.now_ms;

  // Buzzer: a raise restarts the deadline, then the timeout is applied
  logic [31:0] dl_mid;
  logic        on_mid, buzz_tmo;
  assign dl_mid   = (|alerts) ? (item_i.now_ms + BUZZ_MS) : state_i.buzz_deadline;
  assign on_mid   = (|alerts) | state_i.buzz_on;
  assign buzz_tmo = (dl_mid != '0) && (item_i.now_ms >= dl_mid);

  // Next state and result
  always_comb begin
    state_o = state_i;
    res_o   = '0;
    case (item_i.action)
      ACT_CHECK: begin
        state_o.fan_temp   = f_ft;
        state_o.heater     = f_ht;
        state_o.fan_humi   = f_fh;
        state_o.humi_alarm = f_ha;
        state_o.pump       = f_pu;
        state_o.lamp       = f_la;
        state_o.fan_co2    = f_fc;
        for (int i = 0; i < 4; i++) begin
          if (expired[i]) begin
            state_o.ovr_start[i] = '0;
          end
        end
        state_o.buzz_on       = on_mid & !buzz_tmo;
        state_o.buzz_deadline = buzz_tmo ? '0 : dl_mid;
        res_o.pump_write   = en_soil & !live[SLOT_PUMP];
        res_o.pump_level   = res_o.pump_write & f_pu;
        res_o.lamp_write   = en_light & !live[SLOT_LAMP];
        res_o.lamp_level   = res_o.lamp_write & f_la;
        res_o.fan_write    = en_fan & !live[SLOT_FAN];
        res_o.fan_level    = res_o.fan_write & fan_any;
        res_o.heater_write = en_temp & !live[SLOT_HEATER];
        res_o.heater_level = res_o.heater_write & f_ht & !fan_any;
        res_o.new_alerts   = alerts;
      end
      ACT_OVERRIDE: begin
        if (dev_ok) begin
          state_o.ovr_start[dev_slot] = ovr_stamp;
        end
      end
      ACT_DISMISS: begin
        state_o.buzz_on       = 1'b0;
        state_o.buzz_deadline = '0;
      end
      default: begin
      end
    endcase
    res_o.buzzer_active = state_o.buzz_on;
    res_o.humi_low_flag = state_o.humi_alarm;
  end

endmodule

`default_nettype wire

[rtl/hysteresis_relay_controller_unit.sv]
// ----------------------------------------------------------------------------
// hysteresis_relay_controller_unit - greenhouse relay controller top level
//
// Input channel: in_valid_i / in_stall_o with action, time stamp, sensor
// readings and override device; a word is taken when valid is high and
// stall is low. Output channel: out_valid_o / out_stall_i with relay write
// strobes and levels, buzzer state, new alerts and the low-humidity flag.
// Each input word yields exactly one output word.
// out_valid_o rises once a taken word has moved from the input register,
// through evaluation, into the output register, where flags, override slots
// and buzzer state update. Throughput is one word per cycle while the
// receiver does not stall; the state update is registered with each word, so
// back-to-back words see each other.
// When the receiver stalls, the output register holds its word and the
// input register holds the next one; in_stall_o rises only once both are
// full. Reset empties both stages, clears all flags, overrides and buzzer
// state, and loads the default limits. Registers are written over the APB
// port at byte address 4*index; pready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module hysteresis_relay_controller_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] now_ms_i,
  input  logic signed [15:0] temp_tenths_i,
  input  logic [15:0] humi_tenths_i,
  input  logic [15:0] light_level_i,
  input  logic [15:0] soil_level_i,
  input  logic [15:0] co2_level_i,
  input  logic [2:0]  device_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        fan_write_o,
  output logic        fan_level_o,
  output logic        heater_write_o,
  output logic        heater_level_o,
  output logic        pump_write_o,
  output logic        pump_level_o,
  output logic        lamp_write_o,
  output logic        lamp_level_o,
  output logic        buzzer_active_o,
  output logic [6:0]  new_alerts_o,
  output logic        humi_low_flag_o
);
  import hrc_pkg::*;

  // Configuration registers
  cfg_t       cfg_q;
  logic       cfg_we;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ENABLE_MASK: cfg_q.enable_mask      <= pwdata[4:0];
        REG_TEMP_HIGH:   cfg_q.temp_high_limit  <= pwdata[15:0];
        REG_TEMP_LOW:    cfg_q.temp_low_limit   <= pwdata[15:0];
        REG_HUMI_HIGH:   cfg_q.humi_high_limit  <= pwdata[15:0];
        REG_HUMI_LOW:    cfg_q.humi_low_limit   <= pwdata[15:0];
        REG_SOIL_DRY:    cfg_q.soil_dry_limit   <= pwdata[15:0];
        REG_LIGHT_DARK:  cfg_q.light_dark_limit <= pwdata[15:0];
        REG_CO2_HIGH:    cfg_q.co2_high_limit   <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_idx)
      REG_ENABLE_MASK: prdata = {27'd0, cfg_q.enable_mask};
      REG_TEMP_HIGH:   prdata = {16'd0, cfg_q.temp_high_limit};
      REG_TEMP_LOW:    prdata = {16'd0, cfg_q.temp_low_limit};
      REG_HUMI_HIGH:   prdata = {16'd0, cfg_q.humi_high_limit};
      REG_HUMI_LOW:    prdata = {16'd0, cfg_q.humi_low_limit};
      REG_SOIL_DRY:    prdata = {16'd0, cfg_q.soil_dry_limit};
      REG_LIGHT_DARK:  prdata = {16'd0, cfg_q.light_dark_limit};
      REG_CO2_HIGH:    prdata = {16'd0, cfg_q.co2_high_limit};
      default:         prdata = '0;
    endcase
  end

  // Pipeline control
  logic  s1_valid_q, out_valid_q;
  item_t s1_item_q, in_item;
  res_t  res_q, res_d;
  logic  in_take, s1_adv;

  assign s1_adv     = s1_valid_q & (!out_valid_q | !out_stall_i);
  assign in_stall_o = s1_valid_q & !s1_adv;
  assign in_take    = in_valid_i & !in_stall_o;

  assign in_item = '{
    action:      action_e'(action_i),
    now_ms:      now_ms_i,
    temp_tenths: temp_tenths_i,
    humi_tenths: humi_tenths_i,
    light_level: light_level_i,
    soil_level:  soil_level_i,
    co2_level:   co2_level_i,
    device:      device_i
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= in_item;
    end
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  // Controller state
  state_t state_q, state_d;

  hrc_eval u_eval (
    .cfg_i   (cfg_q),
    .item_i  (s1_item_q),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  // Outputs
  assign out_valid_o     = out_valid_q;
  assign fan_write_o     = res_q.fan_write;
  assign fan_level_o     = res_q.fan_level;
  assign heater_write_o  = res_q.heater_write;
  assign heater_level_o  = res_q.heater_level;
  assign pump_write_o    = res_q.pump_write;
  assign pump_level_o    = res_q.pump_level;
  assign lamp_write_o    = res_q.lamp_write;
  assign lamp_level_o    = res_q.lamp_level;
  assign buzzer_active_o = res_q.buzzer_active;
  assign new_alerts_o    = res_q.new_alerts;
  assign humi_low_flag_o = res_q.humi_low_flag;

  // Assertions
  a_no_stall_when_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o
  ) else $error("input stalled while output register empty");

  a_fan_heater_exclusive: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.fan_level && res_q.heater_level)
  ) else $error("fan and heater driven on together");

  a_idle_buzzer_no_deadline: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !state_q.buzz_on |-> (state_q.buzz_deadline == '0)
  ) else $error("buzzer idle with pending deadline");

endmodule

`default_nettype wire

[bench/tb.sv]
// ============================================================================
// tb - self-checking bench for the hysteresis relay controller
// Sends sensor checks, manual overrides and buzzer dismisses over the input
// channel, and keeps its own copy of the flags, override slots and buzzer.
// From that copy it predicts the result word of each accepted input word and
// compares every returned word with it, field by field. The limits and the
// enable mask are reprogrammed over APB between phases, the extremes among
// them. Both channels pause at random.
// ============================================================================
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hrc_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [2:0] DEV_NONE   = 3'd0;
  localparam logic [2:0] DEV_LAMP   = 3'd2;
  localparam logic [2:0] DEV_FAN    = 3'd3;
  localparam logic [2:0] DEV_SPARE  = 3'd7;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTED    = 40;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        now_ms;
    logic signed [15:0] temp;
    logic [15:0]        humi;
    logic [15:0]        light;
    logic [15:0]        soil;
    logic [15:0]        co2;
    logic [2:0]         device;
  } sample_word_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  // APB side
  logic        apb_sel    = 1'b0;
  logic        apb_enable = 1'b0;
  logic        apb_write  = 1'b0;
  logic [4:0]  apb_addr   = '0;
  logic [31:0] apb_wdata  = '0;
  logic [31:0] apb_rdata;
  logic        apb_ready;

  // Input channel
  logic         drv_valid = 1'b0;
  sample_word_t drv_word  = '0;
  logic         in_stall;

  // Output channel
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       fan_write, fan_level, heater_write, heater_level;
  logic       pump_write, pump_level, lamp_write, lamp_level;
  logic       buzzer_active, humi_low_flag;
  logic [6:0] new_alerts;

  hysteresis_relay_controller_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (apb_sel),
    .penable        (apb_enable),
    .pwrite         (apb_write),
    .paddr          (apb_addr),
    .pwdata         (apb_wdata),
    .prdata         (apb_rdata),
    .pready         (apb_ready),
    .in_valid_i     (drv_valid),
    .in_stall_o     (in_stall),
    .action_i       (drv_word.action),
    .now_ms_i       (drv_word.now_ms),
    .temp_tenths_i  (drv_word.temp),
    .humi_tenths_i  (drv_word.humi),
    .light_level_i  (drv_word.light),
    .soil_level_i   (drv_word.soil),
    .co2_level_i    (drv_word.co2),
    .device_i       (drv_word.device),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .fan_write_o    (fan_write),
    .fan_level_o    (fan_level),
    .heater_write_o (heater_write),
    .heater_level_o (heater_level),
    .pump_write_o   (pump_write),
    .pump_level_o   (pump_level),
    .lamp_write_o   (lamp_write),
    .lamp_level_o   (lamp_level),
    .buzzer_active_o(buzzer_active),
    .new_alerts_o   (new_alerts),
    .humi_low_flag_o(humi_low_flag)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Controller copy: programmed limits (power-on values) and state
  // --------------------------------------------------------------------------
  logic [4:0] cf_en      = 5'd0;
  int         cf_temp_hi = 350;
  int         cf_temp_lo = 100;
  int         cf_humi_hi = 800;
  int         cf_humi_lo = 300;
  int         cf_soil    = 3000;
  int         cf_light   = 3000;
  int         cf_co2     = 1500;

  logic        st_fan_temp = 1'b0, st_fan_humi = 1'b0, st_fan_co2 = 1'b0;
  logic        st_heater = 1'b0, st_pump = 1'b0, st_lamp = 1'b0;
  logic        st_humi_alarm = 1'b0;
  logic [31:0] ovr_since [4] = '{default: 32'd0};
  logic [31:0] buzz_deadline = 32'd0;
  logic        buzz_on = 1'b0;

  sample_word_t queued_samples [$];
  res_t         pending_results [$];

  logic idle_on = 1'b1;
  int   gap_left = 0;
  int   stall_left = 0;
  int   errors = 0;
  int   results_seen = 0;
  int   quiet_cycles = 0;
  logic [31:0] sim_ms = 32'd0;
  res_t got_word, want_word;

  // {next flag, raised}: sets strictly above hi, clears strictly below hi - band
  function automatic logic [1:0] hyst_rise(logic flag, int v, int hi, int band);
    if (!flag && v > hi) return 2'b11;
    if (flag && v < hi - band) return 2'b00;
    return {flag, 1'b0};
  endfunction

  // Live override on a slot; an expired one is dropped here
  function automatic logic ovr_live(logic [1:0] slot, logic [31:0] now);
    logic [31:0] elapsed;
    if (ovr_since[slot] == 32'd0) return 1'b0;
    elapsed = now - ovr_since[slot];
    if (elapsed >= OVR_TIMEOUT_MS) begin
      ovr_since[slot] = 32'd0;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Applies one word to the controller copy and returns the result it gives
  function automatic res_t relay_outcome(sample_word_t w);
    res_t       r;
    logic [1:0] hs;
    logic [1:0] slot;
    logic [6:0] raised;
    logic       fan_on;
    int         t, h, l, s, c;
    r = '0;
    raised = '0;
    t = int'($signed(w.temp));
    h = int'(w.humi);
    l = int'(w.light);
    s = int'(w.soil);
    c = int'(w.co2);
    case (w.action)
      ACT_CHECK: begin
        if (cf_en[EN_TEMP]) begin
          hs = hyst_rise(st_fan_temp, t, cf_temp_hi, int'(BAND_TEMP));
          st_fan_temp = hs[1];
          raised[ALR_TEMP_HI] = hs[0];
          // low side: the same rule on negated values
          hs = hyst_rise(st_heater, -t, -cf_temp_lo, int'(BAND_TEMP));
          st_heater = hs[1];
          raised[ALR_TEMP_LO] = hs[0];
        end
        if (cf_en[EN_HUMI]) begin
          hs = hyst_rise(st_fan_humi, h, cf_humi_hi, int'(BAND_HUMI));
          st_fan_humi = hs[1];
          raised[ALR_HUMI_HI] = hs[0];
          hs = hyst_rise(st_humi_alarm, -h, -cf_humi_lo, int'(BAND_HUMI));
          st_humi_alarm = hs[1];
          raised[ALR_HUMI_LO] = hs[0];
        end
        if (cf_en[EN_SOIL]) begin
          hs = hyst_rise(st_pump, s, cf_soil, int'(BAND_SOIL));
          st_pump = hs[1];
          raised[ALR_SOIL] = hs[0];
          if (!ovr_live(SLOT_PUMP, w.now_ms)) begin
            r.pump_write = 1'b1;
            r.pump_level = st_pump;
          end
        end
        if (cf_en[EN_LIGHT]) begin
          hs = hyst_rise(st_lamp, l, cf_light, int'(BAND_LIGHT));
          st_lamp = hs[1];
          raised[ALR_LIGHT] = hs[0];
          if (!ovr_live(SLOT_LAMP, w.now_ms)) begin
            r.lamp_write = 1'b1;
            r.lamp_level = st_lamp;
          end
        end
        if (cf_en[EN_CO2]) begin
          hs = hyst_rise(st_fan_co2, c, cf_co2, int'(BAND_CO2));
          st_fan_co2 = hs[1];
          raised[ALR_CO2] = hs[0];
        end
        if (raised != '0) begin
          buzz_on = 1'b1;
          buzz_deadline = w.now_ms + BUZZ_MS;
        end
        // heater is held off while the fan runs
        fan_on = st_fan_temp | st_fan_humi | st_fan_co2;
        if (cf_en[EN_TEMP] | cf_en[EN_HUMI] | cf_en[EN_CO2]) begin
          if (!ovr_live(SLOT_FAN, w.now_ms)) begin
            r.fan_write = 1'b1;
            r.fan_level = fan_on;
          end
        end
        if (cf_en[EN_TEMP]) begin
          if (!ovr_live(SLOT_HEATER, w.now_ms)) begin
            r.heater_write = 1'b1;
            r.heater_level = !fan_on && st_heater;
          end
        end
        // buzzer timeout, plain unsigned compare; a zero deadline never expires
        if (buzz_deadline != 32'd0 && w.now_ms >= buzz_deadline) begin
          buzz_on = 1'b0;
          buzz_deadline = 32'd0;
        end
      end
      ACT_OVERRIDE: begin
        if (w.device >= DEV_PUMP && w.device <= DEV_HEATER) begin
          slot = w.device[1:0] - 2'd1;
          ovr_since[slot] = (w.now_ms == 32'd0) ? 32'd1 : w.now_ms;
        end
      end
      ACT_DISMISS: begin
        buzz_on = 1'b0;
        buzz_deadline = 32'd0;
      end
      default: ;
    endcase
    r.buzzer_active = buzz_on;
    r.new_alerts = raised;
    r.humi_low_flag = st_humi_alarm;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic sample_word_t make_word(logic [1:0] act, logic [31:0] now,
                                             logic [15:0] t, logic [15:0] h,
                                             logic [15:0] l, logic [15:0] s,
                                             logic [15:0] c, logic [2:0] dev);
    sample_word_t w;
    w.action = act;
    w.now_ms = now;
    w.temp   = t;
    w.humi   = h;
    w.light  = l;
    w.soil   = s;
    w.co2    = c;
    w.device = dev;
    return w;
  endfunction

  // Pause length: mostly none or short, now and then long
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Reading near a limit (within two bands), or anything at all
  function automatic logic [15:0] pick_reading(int lim, int band, logic sgn);
    int v;
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    v = lim + int'($urandom_range(0, 4 * band)) - 2 * band;
    if (sgn) begin
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
    end else begin
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
    end
    return v[15:0];
  endfunction

  // Tick advance: small steps, override-length jumps, wrap region, anywhere
  function automatic logic [31:0] next_tick(logic [31:0] t);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return t + $urandom_range(0, 3000);
    if (r < 92) return t + $urandom_range(250000, 320000);
    if (r < 97) return 32'hFFFF_FFFF - $urandom_range(0, 8000);
    return $urandom;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    apb_sel   <= 1'b1;
    apb_enable <= 1'b0;
    apb_write <= 1'b1;
    apb_addr  <= {idx, 2'b00};
    apb_wdata <= {16'h0000, val};
    @(posedge clk_i);
    apb_enable <= 1'b1;
    @(posedge clk_i);
    apb_sel   <= 1'b0;
    apb_enable <= 1'b0;
    apb_write <= 1'b0;
    case (idx)
      REG_ENABLE_MASK: cf_en      = val[4:0];
      REG_TEMP_HIGH:   cf_temp_hi = int'($signed(val));
      REG_TEMP_LOW:    cf_temp_lo = int'($signed(val));
      REG_HUMI_HIGH:   cf_humi_hi = int'(val);
      REG_HUMI_LOW:    cf_humi_lo = int'(val);
      REG_SOIL_DRY:    cf_soil    = int'(val);
      REG_LIGHT_DARK:  cf_light   = int'(val);
      REG_CO2_HIGH:    cf_co2     = int'(val);
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [4:0] en, input logic [15:0] t_hi,
                            input logic [15:0] t_lo, input logic [15:0] h_hi,
                            input logic [15:0] h_lo, input logic [15:0] soil,
                            input logic [15:0] light, input logic [15:0] co2);
    write_reg(REG_ENABLE_MASK, {11'd0, en});
    write_reg(REG_TEMP_HIGH, t_hi);
    write_reg(REG_TEMP_LOW, t_lo);
    write_reg(REG_HUMI_HIGH, h_hi);
    write_reg(REG_HUMI_LOW, h_lo);
    write_reg(REG_SOIL_DRY, soil);
    write_reg(REG_LIGHT_DARK, light);
    write_reg(REG_CO2_HIGH, co2);
  endtask

  // Settled-side check (falling edge) that every word went through and came back
  task automatic wait_idle();
    @(negedge clk_i);
    while (queued_samples.size() != 0 || drv_valid || pending_results.size() != 0)
      @(negedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic queue_random(input int n);
    sample_word_t w;
    int           r;
    @(negedge clk_i);
    repeat (n) begin
      sim_ms = next_tick(sim_ms);
      r = $urandom_range(0, 99);
      if (r < 74) w.action = ACT_CHECK;
      else if (r < 88) w.action = ACT_OVERRIDE;
      else if (r < 96) w.action = ACT_DISMISS;
      else w.action = ACT_UNUSED;
      w.now_ms = sim_ms;
      w.temp   = pick_reading($urandom_range(0, 1) ? cf_temp_hi : cf_temp_lo,
                              int'(BAND_TEMP), 1'b1);
      w.humi   = pick_reading($urandom_range(0, 1) ? cf_humi_hi : cf_humi_lo,
                              int'(BAND_HUMI), 1'b0);
      w.light  = pick_reading(cf_light, int'(BAND_LIGHT), 1'b0);
      w.soil   = pick_reading(cf_soil, int'(BAND_SOIL), 1'b0);
      w.co2    = pick_reading(cf_co2, int'(BAND_CO2), 1'b0);
      w.device = 3'($urandom);
      queued_samples.push_back(w);
    end
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("MISMATCH word %0d: %s", results_seen, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued words, predicts each one as it is taken
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && !in_stall)
        pending_results.push_back(relay_outcome(drv_word));
      if (!drv_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          drv_valid <= 1'b0;
        end else if (queued_samples.size() != 0) begin
          drv_word <= queued_samples.pop_front();
          drv_valid <= 1'b1;
          gap_left = idle_on ? pick_pause() : 0;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks returned words in order, stalls the output at random
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_word = {fan_write, fan_level, heater_write, heater_level,
                    pump_write, pump_level, lamp_write, lamp_level,
                    buzzer_active, new_alerts, humi_low_flag};
        if (pending_results.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want_word = pending_results.pop_front();
          check_field("fan_write", got_word.fan_write, want_word.fan_write);
          check_field("fan_level", got_word.fan_level, want_word.fan_level);
          check_field("heater_write", got_word.heater_write, want_word.heater_write);
          check_field("heater_level", got_word.heater_level, want_word.heater_level);
          check_field("pump_write", got_word.pump_write, want_word.pump_write);
          check_field("pump_level", got_word.pump_level, want_word.pump_level);
          check_field("lamp_write", got_word.lamp_write, want_word.lamp_write);
          check_field("lamp_level", got_word.lamp_level, want_word.lamp_level);
          check_field("buzzer_active", got_word.buzzer_active, want_word.buzzer_active);
          check_field("new_alerts", got_word.new_alerts, want_word.new_alerts);
          check_field("humi_low_flag", got_word.humi_low_flag, want_word.humi_low_flag);
        end
        results_seen++;
      end
      if (stall_left > 0) stall_left--;
      else if (idle_on) stall_left = pick_pause();
      out_stall <= (stall_left != 0);
    end
  end

  // Watchdog: too long without any word moving on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((drv_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: all checks on, power-on limits
    set_limits(5'h1F, 16'd350, 16'd100, 16'd800, 16'd300, 16'd3000, 16'd3000, 16'd1500);
    idle_on = 1'b1;
    @(negedge clk_i);
    // quiet readings at tick zero, then cold, hot, humid, dry air
    queued_samples.push_back(make_word(ACT_CHECK, 0, 200, 500, 1000, 1000, 800, DEV_NONE));
    queued_samples.push_back(make_word(ACT_CHECK, 100, 50, 500, 1000, 1000, 800, DEV_NONE));
    queued_samples.push_back(make_word(ACT_CHECK, 200, 400, 500, 1000, 1000, 800, DEV_NONE));
    queued_samples.push_back(make_word(ACT_CHECK, 300, 340, 900, 1000, 1000, 800, DEV_NONE));
    queued_samples.push_back(make_word(ACT_CHECK, 400, 200, 100, 1000, 1000, 800, DEV_NONE));
    // dark, dry soil, high CO2
    queued_samples.push_back(make_word(ACT_CHECK, 500, 200, 500, 4000, 4000, 2000, DEV_NONE));
    // overrides: pump at tick zero, the rest later, plus two ignored devices
    queued_samples.push_back(make_word(ACT_OVERRIDE, 0, 200, 500, 1000, 1000, 800, DEV_PUMP));
    queued_samples.push_back(make_word(ACT_OVERRIDE, 600, 200, 500, 1000, 1000, 800, DEV_LAMP));
    queued_samples.push_back(make_word(ACT_OVERRIDE, 600, 200, 500, 1000, 1000, 800, DEV_FAN));
    queued_samples.push_back(make_word(ACT_OVERRIDE, 600, 200, 500, 1000, 1000, 800,
                                       DEV_HEATER));
    queued_samples.push_back(make_word(ACT_OVERRIDE, 600, 200, 500, 1000, 1000, 800, DEV_NONE));
    queued_samples.push_back(make_word(ACT_OVERRIDE, 600, 200, 500, 1000, 1000, 800,
                                       DEV_SPARE));
    // every relay write held back
    queued_samples.push_back(make_word(ACT_CHECK, 700, 200, 500, 1000, 1000, 800, DEV_NONE));
    queued_samples.push_back(make_word(ACT_DISMISS, 800, 200, 500, 1000, 1000, 800, DEV_NONE));
    // unused action with extreme fields: no effect
    queued_samples.push_back(make_word(ACT_UNUSED, 900, 16'h8000, 16'hFFFF, 16'hFFFF,
                                       16'hFFFF, 16'hFFFF, DEV_SPARE));
    // pump override just expired; readings at their maximum
    queued_samples.push_back(make_word(ACT_CHECK, 300001, 16'h7FFF, 16'hFFFF, 16'hFFFF,
                                       16'hFFFF, 16'hFFFF, DEV_NONE));
    // remaining overrides expire; readings at their minimum
    queued_samples.push_back(make_word(ACT_CHECK, 300600, 16'h8000, 0, 0, 0, 0, DEV_NONE));
    // buzzer times out
    queued_samples.push_back(make_word(ACT_CHECK, 306000, 200, 500, 1000, 1000, 800,
                                       DEV_NONE));
    // deadline wraps to zero: buzzer stays on without a timeout
    queued_samples.push_back(make_word(ACT_CHECK, 32'hFFFF_EC78, 50, 500, 1000, 1000, 800,
                                       DEV_NONE));
    queued_samples.push_back(make_word(ACT_CHECK, 32'hFFFF_FFFF, 200, 500, 1000, 1000, 800,
                                       DEV_NONE));
    queued_samples.push_back(make_word(ACT_CHECK, 100, 400, 500, 1000, 1000, 800, DEV_NONE));
    // deadline wraps past zero: buzzer drops in the same word
    queued_samples.push_back(make_word(ACT_CHECK, 32'hFFFF_FF00, 50, 500, 1000, 1000, 800,
                                       DEV_NONE));
    queued_samples.push_back(make_word(ACT_DISMISS, 32'hFFFF_FF10, 200, 500, 1000, 1000, 800,
                                       DEV_NONE));
    // override across the tick wrap is still live
    queued_samples.push_back(make_word(ACT_OVERRIDE, 32'hFFFF_FF20, 200, 500, 1000, 1000, 800,
                                       DEV_FAN));
    queued_samples.push_back(make_word(ACT_CHECK, 100000, 200, 500, 1000, 1000, 800,
                                       DEV_NONE));

    // Random, power-on limits, no pauses
    wait_idle();
    set_limits(5'h1F, 16'd350, 16'd100, 16'd800, 16'd300, 16'd3000, 16'd3000, 16'd1500);
    idle_on = 1'b0;
    queue_random(100);

    // Lowest limits: negative clear bounds never match
    wait_idle();
    set_limits(5'h1F, 16'h8000, 16'h8000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    idle_on = 1'b1;
    queue_random(80);

    // Highest limits: clear bounds above the reading range never match
    wait_idle();
    set_limits(5'h1F, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_random(80);

    // All checks off
    wait_idle();
    set_limits(5'h00, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom), 16'($urandom));
    queue_random(20);

    // Random masks and limits
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      set_limits(5'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom));
      idle_on = (p != 2);
      queue_random(100);
    end

    wait_idle();
    repeat (5) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[hysteresis_relay_controller_unit.f]
rtl/hrc_pkg.sv
rtl/hrc_eval.sv
rtl/hysteresis_relay_controller_unit.sv
bench/tb.sv
